// File: sv/sscd_pkg.sv
package sscd_pkg;

	localparam int NUM_SERVOS  = 6;
	localparam int COORD_CHARS = 9;

	localparam int CHAR_W     = 8;
	localparam int CHARS_MAX  = 9;
	localparam int CHARS_W    = CHARS_MAX * CHAR_W;
	localparam int DIGITS_W   = 3 * CHAR_W;
	localparam int SERVO_W    = 3;
	localparam int ANGLE_W    = 10;
	localparam int PULSE_W    = 12;
	localparam int ADDR_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int COUNT_W    = $clog2(COORD_CHARS);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// pulse mapping arithmetic
	localparam int SPAN_W      = PULSE_W + 1;
	localparam int PROD_W      = ANGLE_W + 1 + SPAN_W;
	localparam int MAG_W       = PROD_W - 1;
	localparam int ANGLE_FULL  = 180;
	localparam int RECIP_SHIFT = 30;
	localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + ANGLE_FULL - 1) / ANGLE_FULL;
	localparam int RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam int QUOT_W      = 15;
	localparam int SUM_W       = QUOT_W + 2;

	localparam logic [CHAR_W-1:0] CH_S    = 8'h73;
	localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_P    = 8'h70;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

	localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd110;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd510;
	localparam logic [PULSE_W-1:0] PULSE_LIMIT   = 12'd4095;
	localparam logic [ADDR_W-1:0]  ADDR_BASE     = 5'd6;
	localparam logic [SERVO_W-1:0] SERVO_RST     = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PULSE_MIN = 1'b0,
		CFG_PULSE_MAX = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		KIND_MOVE  = 1'b0,
		KIND_COORD = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		MODE_SELECT       = 3'd0,
		MODE_ANGLE_ARMED  = 3'd1,
		MODE_ANGLE_DIGITS = 3'd2,
		MODE_POS_ARMED    = 3'd3,
		MODE_POS_CHARS    = 3'd4
	} mode_t;

	// one decoded command; angle digits sit in the top three chars
	typedef struct packed {
		kind_t                kind;
		logic [SERVO_W-1:0]   servo;
		logic [CHARS_W-1:0]   chars;
	} cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_min;
		logic [PULSE_W-1:0] pulse_max;
	} cfg_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

	// leading decimal digits of three chars, first char in the top byte
	function automatic logic [ANGLE_W-1:0] leading_number(input logic [DIGITS_W-1:0] d);
		logic [ANGLE_W-1:0] v;
		logic               run;
		logic [CHAR_W-1:0]  ch;
		v   = '0;
		run = 1'b1;
		for (int k = 0; k < 3; k++) begin
			ch = d[(2 - k) * CHAR_W +: CHAR_W];
			if (run && is_digit(ch)) begin
				v = ANGLE_W'(v * ANGLE_W'(10) + ANGLE_W'(ch - CH_ZERO));
			end else begin
				run = 1'b0;
			end
		end
		return v;
	endfunction

endpackage

// File: sv/sscd_if.sv
interface sscd_rx_if import sscd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink (input valid, input rx_char, output ready);
endinterface

interface sscd_res_if import sscd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [SERVO_W-1:0]   servo_index;
	logic [ANGLE_W-1:0]   angle_value;
	logic [PULSE_W-1:0]   pulse_count;
	logic [ADDR_W-1:0]    register_address;
	logic [DIGITS_W-1:0]  x_chars;
	logic [DIGITS_W-1:0]  y_chars;
	logic [DIGITS_W-1:0]  z_chars;

	modport source (output valid, output kind, output servo_index, output angle_value,
		output pulse_count, output register_address, output x_chars, output y_chars,
		output z_chars, input ready);
	modport sink (input valid, input kind, input servo_index, input angle_value,
		input pulse_count, input register_address, input x_chars, input y_chars,
		input z_chars, output ready);
endinterface

interface sscd_cfg_if import sscd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [PULSE_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/serial_servo_command_decoder_core.sv
// Serial servo command decoder: takes one received byte per request and
// decodes 's' (select, then '0'..'5' picks a servo), 'a' (angle, the letter
// itself is swallowed and the next three bytes are angle chars) and 'p'
// (position, the letter itself is swallowed and the next nine bytes are
// chars). A finished angle gives a move result with the servo, the decoded
// angle, the pulse count pulse_min + angle*(pulse_max-pulse_min)/180 clamped
// to 0..4095 and the channel register address 6+4*servo; a finished
// position gives the nine chars packed three to a field. Throughput is one
// byte per cycle while the result side and the queue do not stall: the
// front decoder, the four-entry command queue and the four-stage mapping
// pipe each take a request every cycle. A result passes through the
// queue, written at the edge that takes its final byte, and then the four
// pipe stages (digit conversion, angle times span, reciprocal multiply for
// the /180, add and clamp into the result register). A stalled result holds
// the whole pipe; once the queue is full the rx side stops taking bytes.
// pulse_min and pulse_max are written through the cfg port.
module serial_servo_command_decoder_core import sscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sscd_rx_if.sink     rx,
	sscd_res_if.source  res,
	sscd_cfg_if.sink    cfg
);

	cfg_t cfg_q;
	cmd_t push_cmd, pop_cmd;
	logic push_valid, push_ready;
	logic pop_valid, pop_ready;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min <= PULSE_MIN_RST;
			cfg_q.pulse_max <= PULSE_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PULSE_MIN: cfg_q.pulse_min <= cfg.data;
				CFG_PULSE_MAX: cfg_q.pulse_max <= cfg.data;
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// byte decoder and mode tracking
	sscd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// decouples decoding from the mapping pipe
	sscd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (push_cmd),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.out_cmd   (pop_cmd),
		.out_valid (pop_valid),
		.out_ready (pop_ready)
	);

	// angle conversion, pulse mapping and result register
	sscd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_cmd   (pop_cmd),
		.in_valid (pop_valid),
		.in_ready (pop_ready),
		.cfg      (cfg_q),
		.res      (res)
	);

`ifndef SYNTH
	// a command letter never completes a command
	a_letter_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(rx.valid && rx.ready && (rx.rx_char == CH_A || rx.rx_char == CH_P ||
		rx.rx_char == CH_S)) |-> !push_valid)
		else $error("command letter produced a queue write");

	// the decoder only writes the queue for an accepted byte
	a_push_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (rx.valid && rx.ready))
		else $error("queue write without an accepted byte");

	// a queue write is never dropped
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("queue write while full");
`endif

endmodule

// File: sv/sscd_front.sv
module sscd_front import sscd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sscd_rx_if.sink   rx,
	output cmd_t      push_cmd,
	output logic      push_valid,
	input  logic      push_ready
);

	mode_t              mode_q, mode_d, eff_mode;
	logic [SERVO_W-1:0] servo_q, servo_d;
	logic [1:0]         dcnt_q, dcnt_d;
	logic [COUNT_W-1:0] ccnt_q, ccnt_d;
	logic [CHAR_W-1:0]  digit_q [2];
	logic [CHAR_W-1:0]  chars_q [CHARS_MAX];
	logic [CHAR_W-1:0]  chars_next [CHARS_MAX];
	logic [CHAR_W-1:0]  ch, sel;
	logic               accept, digit_we, chars_we;

	assign rx.ready = push_ready;
	assign accept   = rx.valid & rx.ready;
	assign ch       = rx.rx_char;
	assign sel      = ch - CH_ZERO;

	always_comb begin
		for (int i = 0; i < CHARS_MAX; i++) begin
			chars_next[i] = (i == int'(ccnt_q)) ? ch : chars_q[i];
		end
	end

	always_comb begin
		priority if (ch == CH_S) begin
			eff_mode = MODE_SELECT;
		end else if (ch == CH_A) begin
			eff_mode = MODE_ANGLE_ARMED;
		end else if (ch == CH_P) begin
			eff_mode = MODE_POS_ARMED;
		end else begin
			eff_mode = mode_q;
		end

		mode_d         = mode_q;
		servo_d        = servo_q;
		dcnt_d         = dcnt_q;
		ccnt_d         = ccnt_q;
		digit_we       = 1'b0;
		chars_we       = 1'b0;
		push_valid     = 1'b0;
		push_cmd.kind  = KIND_MOVE;
		push_cmd.servo = servo_q;
		push_cmd.chars = {digit_q[0], digit_q[1], ch, {(CHARS_W - DIGITS_W){1'b0}}};
		for (int i = 0; i < CHARS_MAX; i++) begin
			if (i >= 3) begin
				push_cmd.chars[(CHARS_MAX - 1 - i) * CHAR_W +: CHAR_W] = '0;
			end
		end

		if (accept) begin
			mode_d = eff_mode;
			unique case (eff_mode)
				MODE_SELECT: begin
					if (is_digit(ch) && (sel < CHAR_W'(NUM_SERVOS))) begin
						servo_d = SERVO_W'(sel);
					end
				end
				MODE_ANGLE_ARMED: mode_d = MODE_ANGLE_DIGITS;
				MODE_ANGLE_DIGITS: begin
					if (dcnt_q == 2'd2) begin
						dcnt_d     = 2'd0;
						push_valid = 1'b1;
					end else begin
						dcnt_d   = dcnt_q + 2'd1;
						digit_we = 1'b1;
					end
				end
				MODE_POS_ARMED: mode_d = MODE_POS_CHARS;
				MODE_POS_CHARS: begin
					chars_we = 1'b1;
					if (ccnt_q == COUNT_W'(COORD_CHARS - 1)) begin
						ccnt_d         = '0;
						push_valid     = 1'b1;
						push_cmd.kind  = KIND_COORD;
						push_cmd.servo = '0;
						for (int i = 0; i < CHARS_MAX; i++) begin
							push_cmd.chars[(CHARS_MAX - 1 - i) * CHAR_W +: CHAR_W] =
								chars_next[i];
						end
					end else begin
						ccnt_d = ccnt_q + COUNT_W'(1);
					end
				end
				default: mode_d = mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SELECT;
			servo_q <= SERVO_RST;
			dcnt_q  <= '0;
			ccnt_q  <= '0;
			for (int i = 0; i < CHARS_MAX; i++) begin
				chars_q[i] <= '0;
			end
		end else begin
			mode_q  <= mode_d;
			servo_q <= servo_d;
			dcnt_q  <= dcnt_d;
			ccnt_q  <= ccnt_d;
			if (chars_we) begin
				for (int i = 0; i < CHARS_MAX; i++) begin
					chars_q[i] <= chars_next[i];
				end
			end
		end
	end

	// angle digits hold no reset value
	always_ff @(posedge clk) begin
		if (digit_we) begin
			digit_q[dcnt_q[0]] <= ch;
		end
	end

endmodule

// File: sv/sscd_fifo.sv
module sscd_fifo import sscd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t in_cmd,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t out_cmd,
	output logic out_valid,
	input  logic out_ready
);

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]   cnt_q;
	logic                  push, pop;

	assign in_ready  = cnt_q != (FIFO_PTR_W + 1)'(FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (FIFO_PTR_W + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (FIFO_PTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// File: sv/sscd_back.sv
module sscd_back import sscd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        in_cmd,
	input  logic        in_valid,
	output logic        in_ready,
	input  cfg_t        cfg,
	sscd_res_if.source  res
);

	logic                     adv;
	logic                     v_s1, v_s2, v_s3, v_s4;
	kind_t                    kind_s1, kind_s2, kind_s3, kind_s4;
	logic [SERVO_W-1:0]       servo_s1, servo_s2, servo_s3, servo_s4;
	logic [CHARS_W-1:0]       chars_s1, chars_s2, chars_s3, chars_s4;
	logic [ANGLE_W-1:0]       angle_s1, angle_s2, angle_s3, angle_s4;
	logic [ADDR_W-1:0]        addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [SPAN_W-1:0] span_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     neg_s3;
	logic [QUOT_W-1:0]        quot_s3;
	logic [PULSE_W-1:0]       pulse_s4;
	logic [MAG_W-1:0]         mag;
	logic [MAG_W+RECIP_W-1:0] scaled;
	logic signed [SUM_W-1:0]  sum;
	logic [PULSE_W-1:0]       clamped;

	// the whole pipe moves when the output register is free or drained
	assign adv      = !v_s4 | res.ready;
	assign in_ready = adv;

	// magnitude times reciprocal of 180 gives the truncated quotient
	assign mag    = prod_s2[PROD_W-1] ? MAG_W'(-prod_s2) : MAG_W'(prod_s2);
	assign scaled = (MAG_W + RECIP_W)'(mag) * (MAG_W + RECIP_W)'(RECIP);

	always_comb begin
		sum = $signed({{(SUM_W - PULSE_W){1'b0}}, cfg.pulse_min});
		if (neg_s3) begin
			sum = sum - $signed({2'b00, quot_s3});
		end else begin
			sum = sum + $signed({2'b00, quot_s3});
		end
		priority if (sum < 0) begin
			clamped = '0;
		end else if (sum > $signed({{(SUM_W - PULSE_W){1'b0}}, PULSE_LIMIT})) begin
			clamped = PULSE_LIMIT;
		end else begin
			clamped = PULSE_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= in_cmd.kind;
			servo_s1 <= in_cmd.servo;
			chars_s1 <= in_cmd.chars;
			angle_s1 <= leading_number(in_cmd.chars[CHARS_W-1 -: DIGITS_W]);
			addr_s1  <= ADDR_BASE + {in_cmd.servo, 2'b00};
			span_s1  <= $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});

			kind_s2  <= kind_s1;
			servo_s2 <= servo_s1;
			chars_s2 <= chars_s1;
			angle_s2 <= angle_s1;
			addr_s2  <= addr_s1;
			prod_s2  <= PROD_W'($signed({1'b0, angle_s1})) * PROD_W'(span_s1);

			kind_s3  <= kind_s2;
			servo_s3 <= servo_s2;
			chars_s3 <= chars_s2;
			angle_s3 <= angle_s2;
			addr_s3  <= addr_s2;
			neg_s3   <= prod_s2[PROD_W-1];
			quot_s3  <= scaled[RECIP_SHIFT +: QUOT_W];

			kind_s4  <= kind_s3;
			if (kind_s3 == KIND_COORD) begin
				servo_s4 <= '0;
				angle_s4 <= '0;
				pulse_s4 <= '0;
				addr_s4  <= '0;
				chars_s4 <= chars_s3;
			end else begin
				servo_s4 <= servo_s3;
				angle_s4 <= angle_s3;
				pulse_s4 <= clamped;
				addr_s4  <= addr_s3;
				chars_s4 <= '0;
			end
		end
	end

	assign res.valid            = v_s4;
	assign res.kind             = kind_s4;
	assign res.servo_index      = servo_s4;
	assign res.angle_value      = angle_s4;
	assign res.pulse_count      = pulse_s4;
	assign res.register_address = addr_s4;
	assign res.x_chars          = chars_s4[CHARS_W-1 -: DIGITS_W];
	assign res.y_chars          = chars_s4[CHARS_W-DIGITS_W-1 -: DIGITS_W];
	assign res.z_chars          = chars_s4[DIGITS_W-1:0];

endmodule

// File: bench/servo_result_checker.sv
module servo_result_checker import sscd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sscd_rx_if   rx,
	sscd_res_if  res,
	sscd_cfg_if  cfg,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t               kind;
		logic [SERVO_W-1:0]  servo;
		logic [ANGLE_W-1:0]  angle;
		logic [PULSE_W-1:0]  pulse;
		logic [ADDR_W-1:0]   addr;
		logic [DIGITS_W-1:0] x;
		logic [DIGITS_W-1:0] y;
		logic [DIGITS_W-1:0] z;
	} servo_result_t;

	servo_result_t      pending_results[$];
	logic [PULSE_W-1:0] pulse_lo;
	logic [PULSE_W-1:0] pulse_hi;
	mode_t              cur_mode;
	logic [SERVO_W-1:0] sel_servo;
	int                 digit_cnt;
	int                 coord_cnt;
	logic [CHAR_W-1:0]  angle_chars[3];
	logic [CHAR_W-1:0]  coord_bytes[CHARS_MAX];
	int                 fail_cnt = 0;
	int                 pend_cnt = 0;

	assign errors      = fail_cnt;
	assign outstanding = pend_cnt;

	function automatic servo_result_t blank_result();
		servo_result_t r;
		r.kind  = KIND_MOVE;
		r.servo = '0;
		r.angle = '0;
		r.pulse = '0;
		r.addr  = '0;
		r.x     = '0;
		r.y     = '0;
		r.z     = '0;
		return r;
	endfunction

	// one received byte through the command decoder
	task automatic decode_byte(input logic [CHAR_W-1:0] c);
		servo_result_t r;
		int            ang;
		int            k;
		bit            stop;
		longint        span;
		longint        p;
		r = blank_result();
		if (c == CH_S) begin
			cur_mode = MODE_SELECT;
		end else if (c == CH_A) begin
			cur_mode = MODE_ANGLE_ARMED;
		end else if (c == CH_P) begin
			cur_mode = MODE_POS_ARMED;
		end
		case (cur_mode)
			MODE_SELECT: begin
				if (c >= CH_ZERO && int'(c) < int'(CH_ZERO) + NUM_SERVOS)
					sel_servo = SERVO_W'(c - CH_ZERO);
			end
			MODE_ANGLE_ARMED: cur_mode = MODE_ANGLE_DIGITS;
			MODE_ANGLE_DIGITS: begin
				angle_chars[digit_cnt] = c;
				digit_cnt++;
				if (digit_cnt == 3) begin
					digit_cnt = 0;
					ang  = 0;
					stop = 1'b0;
					for (k = 0; k < 3; k++) begin
						if (stop || angle_chars[k] < CH_ZERO || angle_chars[k] > CH_NINE)
							stop = 1'b1;
						else
							ang = ang * 10 + int'(angle_chars[k] - CH_ZERO);
					end
					// signed span, quotient truncated toward zero, then clamp
					span = longint'(pulse_hi) - longint'(pulse_lo);
					p    = longint'(pulse_lo) + (longint'(ang) * span) / 180;
					if (p < 0)
						p = 0;
					if (p > 4095)
						p = 4095;
					r.kind  = KIND_MOVE;
					r.servo = sel_servo;
					r.angle = ANGLE_W'(ang);
					r.pulse = PULSE_W'(p);
					r.addr  = ADDR_W'(6 + 4 * int'(sel_servo));
					pending_results.push_back(r);
				end
			end
			MODE_POS_ARMED: cur_mode = MODE_POS_CHARS;
			MODE_POS_CHARS: begin
				coord_cnt++;
				if (coord_cnt >= 1 && coord_cnt <= COORD_CHARS) begin
					coord_bytes[coord_cnt - 1] = c;
					if (coord_cnt == COORD_CHARS) begin
						coord_cnt = 0;
						r.kind = KIND_COORD;
						r.x    = {coord_bytes[0], coord_bytes[1], coord_bytes[2]};
						r.y    = {coord_bytes[3], coord_bytes[4], coord_bytes[5]};
						r.z    = {coord_bytes[6], coord_bytes[7], coord_bytes[8]};
						pending_results.push_back(r);
					end
				end else begin
					coord_cnt = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input servo_result_t e, input servo_result_t a);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected kind %0d servo %0d angle %0d pulse %0d addr %0d xyz %h %h %h",
				e.kind, e.servo, e.angle, e.pulse, e.addr, e.x, e.y, e.z);
			$display("  actual   kind %0d servo %0d angle %0d pulse %0d addr %0d xyz %h %h %h",
				a.kind, a.servo, a.angle, a.pulse, a.addr, a.x, a.y, a.z);
		end
	endtask

	task automatic check_result();
		servo_result_t e;
		servo_result_t a;
		a.kind  = kind_t'(res.kind);
		a.servo = res.servo_index;
		a.angle = res.angle_value;
		a.pulse = res.pulse_count;
		a.addr  = res.register_address;
		a.x     = res.x_chars;
		a.y     = res.y_chars;
		a.z     = res.z_chars;
		if (pending_results.size() == 0) begin
			report("result with nothing pending", blank_result(), a);
		end else begin
			e = pending_results.pop_front();
			if (a.kind !== e.kind || a.servo !== e.servo || a.angle !== e.angle
					|| a.pulse !== e.pulse || a.addr !== e.addr
					|| a.x !== e.x || a.y !== e.y || a.z !== e.z)
				report("result mismatch", e, a);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pulse_lo  = PULSE_MIN_RST;
			pulse_hi  = PULSE_MAX_RST;
			cur_mode  = MODE_SELECT;
			sel_servo = SERVO_RST;
			digit_cnt = 0;
			coord_cnt = 0;
			foreach (angle_chars[i])
				angle_chars[i] = '0;
			foreach (coord_bytes[i])
				coord_bytes[i] = '0;
			pending_results.delete();
		end else begin
			// results first: none can stem from a byte taken at the same edge
			if (res.valid && res.ready)
				check_result();
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_PULSE_MIN)
					pulse_lo = cfg.data;
				else
					pulse_hi = cfg.data;
			end
			if (rx.valid && rx.ready)
				decode_byte(rx.rx_char);
		end
		pend_cnt <= pending_results.size();
	end

endmodule

// File: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sscd_pkg::*;

	// timing of the run
	localparam int RESULT_HOLD   = 80;    // long receiver hold-off, fills the result path
	localparam int STALL_LIMIT   = 2000;  // cycles with no request taken anywhere
	localparam int SETTLE_CYCLES = 10;    // margin for the pipe latency
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 250;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   quiet_cycles = 0;
	int   bytes_sent   = 0;
	bit   jitter       = 1'b0;
	bit   hold_request = 1'b0;
	bit   hold_served  = 1'b0;

	sscd_rx_if  rx_ch();
	sscd_res_if res_ch();
	sscd_cfg_if cfg_ch();

	serial_servo_command_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	servo_result_checker results_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any request taken on any channel counts as progress
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin : result_sink
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				// the sender keeps going, so the queue and pipe back up into rx
				res_ch.ready <= 1'b0;
				repeat (RESULT_HOLD) @(posedge clk);
				hold_served = 1'b1;
				res_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else if (jitter && $urandom_range(0, 6) == 0) begin
				// start a burst of stalled cycles
				res_ch.ready <= 1'b0;
				stall = $urandom_range(0, 2);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// one byte request; valid stays up between back-to-back requests
	task automatic send_byte(input logic [CHAR_W-1:0] c);
		if (jitter && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_char <= c;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string t);
		int k;
		for (k = 0; k < t.len(); k++)
			send_byte(t[k]);
	endtask

	// drop valid, let every pending result drain, then cover the pipe latency
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both mapping registers, back to back on the cfg port
	task automatic write_range(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_PULSE_MIN;
		cfg_ch.data  <= lo;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.index <= CFG_PULSE_MAX;
		cfg_ch.data  <= hi;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// any byte except a command letter, so a sequence stays well formed
	function automatic logic [CHAR_W-1:0] data_byte();
		logic [CHAR_W-1:0] c;
		c = CHAR_W'($urandom_range(0, 255));
		if (c == CH_S || c == CH_A || c == CH_P)
			c ^= 8'h01;
		return c;
	endfunction

	// mostly decimal digits, sometimes a stray char that ends the number early
	function automatic logic [CHAR_W-1:0] angle_byte();
		if ($urandom_range(0, 9) < 8)
			return CH_ZERO + CHAR_W'($urandom_range(0, 9));
		return data_byte();
	endfunction

	function automatic logic [CHAR_W-1:0] letter_or_noise();
		case ($urandom_range(0, 3))
			0: return CH_S;
			1: return CH_A;
			2: return CH_P;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// one random command: mostly well formed, some cut short, some noise
	task automatic send_command();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_byte(CH_S);
			if ($urandom_range(0, 3) == 0)
				send_byte(CHAR_W'($urandom_range(0, 255)));
			else
				send_byte(CH_ZERO + CHAR_W'($urandom_range(0, NUM_SERVOS - 1)));
		end else if (pick < 62) begin
			send_byte(CH_A);
			repeat (3) send_byte(angle_byte());
		end else if (pick < 82) begin
			send_byte(CH_P);
			repeat (COORD_CHARS) send_byte(data_byte());
		end else if (pick < 92) begin
			// broken off: the counters resume on the next angle or position
			send_byte($urandom_range(0, 1) ? CH_A : CH_P);
			n = $urandom_range(0, 2);
			repeat (n) send_byte(angle_byte());
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(letter_or_noise());
		end
	endtask

	initial begin : stimulus
		logic [PULSE_W-1:0] lo;
		logic [PULSE_W-1:0] hi;
		int                 phase;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_char = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = CFG_PULSE_MIN;
		cfg_ch.data   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset mapping
		jitter = 1'b1;
		write_range(PULSE_MIN_RST, PULSE_MAX_RST);
		// move on the reset servo, angle zero
		send_text("a000");
		// pick servo 0, full-scale angle
		send_text("s0a180");
		// out-of-range select digits are ignored
		send_text("s9s6");
		// position with extreme and non-printing chars
		send_byte(CH_P);
		send_byte(8'h00);
		send_byte(8'hff);
		send_text("12x");
		send_byte(8'h80);
		send_byte(8'h7f);
		send_text("09");
		wait_idle();

		// random part over a series of mapping ranges, extremes first
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin lo = PULSE_MIN_RST; hi = PULSE_MAX_RST; end
				1: begin lo = '0;            hi = PULSE_LIMIT;   end
				2: begin lo = PULSE_LIMIT;   hi = '0;            end
				3: begin lo = '0;            hi = '0;            end
				4: begin lo = PULSE_LIMIT;   hi = PULSE_LIMIT;   end
				default: begin
					lo = PULSE_W'($urandom_range(0, 4095));
					hi = PULSE_W'($urandom_range(0, 4095));
				end
			endcase
			// one quiet phase in the middle, and the last phase has no idling
			jitter = (phase != 3) && (phase != PHASES - 1);
			write_range(lo, hi);
			if (phase == 1)
				hold_request = 1'b1;
			bytes_sent = 0;
			while (bytes_sent < PHASE_ITEMS)
				send_command();
			// registers only change once the block has gone idle
			wait_idle();
		end

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: sim.f
sv/sscd_pkg.sv
sv/sscd_if.sv
sv/sscd_front.sv
sv/sscd_fifo.sv
sv/sscd_back.sv
sv/serial_servo_command_decoder_core.sv
bench/servo_result_checker.sv
bench/testbench.sv
